@@ rtl/coverage_grid_marker_assert.svh @@
// Assertion macros shared by the coverage grid marker RTL.
// Expects clk and arst_n in the scope of the including module.
`ifndef COVERAGE_GRID_MARKER_ASSERT_SVH
`define COVERAGE_GRID_MARKER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CGM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CGM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cgm_pkg.sv @@
// Shared types, constants and helper functions of the coverage grid marker.
// Used by every module of the block but cgm_map_ram; depends on nothing else.
package cgm_pkg;

	// Doubled coordinates (half Q8.8 steps) of cell centres and poses.
	localparam int CW    = 27;
	// One squared difference, the mark distance and the find cost.
	localparam int SQ_W  = 50;
	localparam int DM_W  = 51;
	localparam int DF_W  = 53;
	// Squared doubled footprint radius.
	localparam int LIM_W = 32;

	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam int CNT_OUT_W = 13;
	localparam logic [CNT_OUT_W-1:0] CNT_SAT = 13'h1fff;

	localparam logic [1:0] OP_MARK  = 2'd0;
	localparam logic [1:0] OP_FIND  = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [2:0] REG_CELL_SIZE  = 3'd0;
	localparam logic [2:0] REG_FOOTPRINT  = 3'd1;
	localparam logic [2:0] REG_FLD_X_LO   = 3'd2;
	localparam logic [2:0] REG_FLD_X_HI   = 3'd3;
	localparam logic [2:0] REG_ZONE_Y_MIN = 3'd4;
	localparam logic [2:0] REG_ZONE_Y_MAX = 3'd5;
	localparam logic [2:0] REG_INTERVAL   = 3'd6;
	localparam logic [2:0] REG_SUFFICIENT = 3'd7;

	localparam logic signed [CW-1:0] SAT_HI = CW'(32767);
	localparam logic signed [CW-1:0] SAT_LO = CW'(-32768);

	typedef struct packed {
		logic [14:0]        cell_size;
		logic [14:0]        footprint_radius;
		logic signed [15:0] fld_x_lo;
		logic signed [15:0] fld_x_hi;
		logic signed [15:0] zone_y_min;
		logic signed [15:0] zone_y_max;
		logic [15:0]        mark_interval_ms;
		logic [12:0]        sufficient_count;
	} cfg_t;

	typedef struct packed {
		logic                 valid;
		logic                 busy;
		logic                 scanned;
		logic signed [CW-1:0] x2;
		logic signed [CW-1:0] y2;
		logic [DM_W-1:0]      dist_mark;
		logic [DF_W-1:0]      dist_find;
	} pipe_out_t;

	// Halve a doubled coordinate rounding toward minus infinity, then
	// saturate it to a 16-bit Q8.8 value.
	function automatic logic [15:0] half_sat16(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] h;
		h = v >>> 1;
		if (h > SAT_HI) begin
			return 16'h7fff;
		end else if (h < SAT_LO) begin
			return 16'h8000;
		end else begin
			return h[15:0];
		end
	endfunction

endpackage

@@ rtl/cgm_cfg_regs.sv @@
// Configuration register file of the coverage grid marker on an APB-style port.
// Depends on cgm_pkg for the register indexes and the configuration struct.
module cgm_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cgm_pkg::ADDR_W-1:0]  paddr,
	input  logic [cgm_pkg::DATA_W-1:0]  pwdata,
	output logic [cgm_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output cgm_pkg::cfg_t               cfg
);
	import cgm_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] index;
	logic       wr_en;

	assign index  = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_size        <= 15'd256;
			cfg_q.footprint_radius <= 15'd512;
			cfg_q.fld_x_lo         <= 16'sd0;
			cfg_q.fld_x_hi         <= 16'sd32767;
			cfg_q.zone_y_min       <= 16'sd0;
			cfg_q.zone_y_max       <= 16'sd32767;
			cfg_q.mark_interval_ms <= 16'd100;
			cfg_q.sufficient_count <= 13'd3686;
		end else if (wr_en) begin
			unique case (index)
				REG_CELL_SIZE:  cfg_q.cell_size        <= pwdata[14:0];
				REG_FOOTPRINT:  cfg_q.footprint_radius <= pwdata[14:0];
				REG_FLD_X_LO:   cfg_q.fld_x_lo         <= pwdata[15:0];
				REG_FLD_X_HI:   cfg_q.fld_x_hi         <= pwdata[15:0];
				REG_ZONE_Y_MIN: cfg_q.zone_y_min       <= pwdata[15:0];
				REG_ZONE_Y_MAX: cfg_q.zone_y_max       <= pwdata[15:0];
				REG_INTERVAL:   cfg_q.mark_interval_ms <= pwdata[15:0];
				REG_SUFFICIENT: cfg_q.sufficient_count <= pwdata[12:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (index)
			REG_CELL_SIZE:  prdata = {17'b0, cfg_q.cell_size};
			REG_FOOTPRINT:  prdata = {17'b0, cfg_q.footprint_radius};
			REG_FLD_X_LO:   prdata = {16'b0, cfg_q.fld_x_lo};
			REG_FLD_X_HI:   prdata = {16'b0, cfg_q.fld_x_hi};
			REG_ZONE_Y_MIN: prdata = {16'b0, cfg_q.zone_y_min};
			REG_ZONE_Y_MAX: prdata = {16'b0, cfg_q.zone_y_max};
			REG_INTERVAL:   prdata = {16'b0, cfg_q.mark_interval_ms};
			REG_SUFFICIENT: prdata = {19'b0, cfg_q.sufficient_count};
			default:        prdata = '0;
		endcase
	end

endmodule

@@ rtl/cgm_map_ram.sv @@
// One-bit scanned map memory: one write port and one registered read port.
// Standalone; sized by the top level.
module cgm_map_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/cgm_dist_pipe.sv @@
// Three-stage distance pipeline: differences, squares, then the mark distance
// and the find cost of one cell. Depends on cgm_pkg for widths and the result struct.
module cgm_dist_pipe #(
	parameter int AW = 12
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [AW-1:0]                 in_addr,
	input  logic signed [cgm_pkg::CW-1:0] in_x2,
	input  logic signed [cgm_pkg::CW-1:0] in_y2,
	input  logic signed [15:0]            pos_x,
	input  logic signed [15:0]            pos_y,
	input  logic signed [15:0]            lane_x,
	input  logic                          map_bit,
	output logic [AW-1:0]                 out_addr,
	output cgm_pkg::pipe_out_t            out
);
	import cgm_pkg::*;

	logic signed [CW-1:0]   px2, py2, lx2;
	logic                   v_s1, v_s2, v_s3;
	logic [AW-1:0]          addr_s1, addr_s2, addr_s3;
	logic signed [CW-1:0]   x2_s1, y2_s1, x2_s2, y2_s2, x2_s3, y2_s3;
	logic signed [CW-1:0]   dx_s1, dy_s1, dl_s1;
	logic signed [2*CW-1:0] px_sq, py_sq, pl_sq;
	logic [SQ_W-1:0]        sx_s2, sy_s2, sl_s2;
	logic                   bit_s2, bit_s3;
	logic [DM_W-1:0]        dm_s3;
	logic [DF_W-1:0]        df_s3;

	assign px2 = {{(CW-17){pos_x[15]}}, pos_x, 1'b0};
	assign py2 = {{(CW-17){pos_y[15]}}, pos_y, 1'b0};
	assign lx2 = {{(CW-17){lane_x[15]}}, lane_x, 1'b0};

	assign px_sq = dx_s1 * dx_s1;
	assign py_sq = dy_s1 * dy_s1;
	assign pl_sq = dl_s1 * dl_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= in_addr;
		x2_s1   <= in_x2;
		y2_s1   <= in_y2;
		dx_s1   <= in_x2 - px2;
		dy_s1   <= in_y2 - py2;
		dl_s1   <= in_x2 - lx2;

		// The map read issued with this cell lands here.
		addr_s2 <= addr_s1;
		x2_s2   <= x2_s1;
		y2_s2   <= y2_s1;
		bit_s2  <= map_bit;
		sx_s2   <= px_sq[SQ_W-1:0];
		sy_s2   <= py_sq[SQ_W-1:0];
		sl_s2   <= pl_sq[SQ_W-1:0];

		addr_s3 <= addr_s2;
		x2_s3   <= x2_s2;
		y2_s3   <= y2_s2;
		bit_s3  <= bit_s2;
		dm_s3   <= DM_W'(sx_s2) + DM_W'(sy_s2);
		df_s3   <= DF_W'(sx_s2) + DF_W'(sy_s2) + {1'b0, sl_s2, 2'b00};
	end

	assign out_addr      = addr_s3;
	assign out.valid     = v_s3;
	assign out.busy      = v_s1 || v_s2 || v_s3;
	assign out.scanned   = bit_s3;
	assign out.x2        = x2_s3;
	assign out.y2        = y2_s3;
	assign out.dist_mark = dm_s3;
	assign out.dist_find = df_s3;

endmodule

@@ rtl/coverage_grid_marker.sv @@
// Top level of the coverage grid marker: stream channels, control sequencer,
// map memory and distance pipeline. Depends on cgm_pkg and the blocks in rtl/.
//
// Usage. Each input transaction carries one operation in s_tuser (mark, find
// or clear) and a pose, a lane and a millisecond time in s_tdata. Each input
// transaction produces exactly one output transaction on the m_ side with the
// mark and find flags in m_tuser and the target, the scanned count and the
// sufficiency flag in m_tdata. Registers are written over the APB-style port;
// the user must write them only while idle, which the block does not enforce.
// Timing. A mark that passes its time and field tests and every find walk the
// whole map once, one cell per cycle through the map memory read port. A clear
// writes one cell per cycle through the memory write port. A rejected mark and
// the unused operation code skip the map and go straight to the result.
// One operation is in flight at a time.
// Reset. After arst_n is released the block clears the map with a pass over
// every cell; s_tready stays low during that pass, while configuration writes
// are taken as usual.
// Stalls. The result sits in an output register. The block takes the next
// input transaction while that result waits; a later result waits for the
// register to be drained by m_tready.
`include "coverage_grid_marker_assert.svh"

module coverage_grid_marker #(
	parameter int GRID_ROWS = 64,
	parameter int GRID_COLS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// Input stream.
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// s_tdata: pos_x [15:0], pos_y [31:16], lane_x [47:32], now_ms [79:48]
	input  logic [79:0]                s_tdata,
	// s_tuser: operation [1:0]
	input  logic [1:0]                 s_tuser,
	// Result stream.
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// m_tdata: target_x [15:0], target_y [31:16], scanned_count [44:32],
	//          coverage_sufficient [45], zero [47:46]
	output logic [47:0]                m_tdata,
	// m_tuser: mark_applied [0], found [1]
	output logic [1:0]                 m_tuser,
	// Configuration port.
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [cgm_pkg::ADDR_W-1:0] paddr,
	input  logic [cgm_pkg::DATA_W-1:0] pwdata,
	output logic [cgm_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);
	import cgm_pkg::*;

	localparam int NUM_CELLS = GRID_ROWS * GRID_COLS;
	localparam int IDX_W     = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
	localparam int COL_W     = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int CNT_W     = $clog2(NUM_CELLS + 1);
	localparam int EXT_W     = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

	// Sequencer states.
	localparam logic [2:0] ST_INIT  = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_CLEAR = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	cfg_t      cfg;
	pipe_out_t pipe_out;

	logic [2:0]             state_q;
	logic [IDX_W-1:0]       clr_q;
	logic [IDX_W-1:0]       idx_q;
	logic [COL_W-1:0]       col_q;
	logic signed [CW-1:0]   x2_q, y2_q;
	logic [1:0]             op_q;
	logic signed [15:0]     px_q, py_q, lane_q;
	logic [LIM_W-1:0]       lim_q;
	logic [31:0]            last_mark_q;
	logic [CNT_W-1:0]       marked_total_q;
	logic                   applied_q;
	logic                   have_q;
	logic [DF_W-1:0]        best_q;
	logic signed [CW-1:0]   bx_q, by_q;
	logic                   m_tvalid_q;
	logic [47:0]            m_tdata_q;
	logic [1:0]             m_tuser_q;

	logic [1:0]             in_op;
	logic signed [15:0]     in_px, in_py, in_lane;
	logic [31:0]            in_now;
	logic                   s_acc;
	logic                   time_ok;
	logic                   in_field;
	logic                   start_scan;
	logic [LIM_W-1:0]       lim_w;
	logic [15:0]            radius2;
	logic signed [CW-1:0]   cell_ext, cell2, zmin2;
	logic [IDX_W-1:0]       pipe_addr;
	logic                   map_rdata;
	logic                   map_we;
	logic [IDX_W-1:0]       map_waddr;
	logic                   map_wdata;
	logic                   mark_hit, find_hit;
	logic                   in_walk;
	logic                   out_load;
	logic [EXT_W-1:0]       total_ext;
	logic [CNT_OUT_W-1:0]   count_sat;
	logic                   sufficient;
	logic [15:0]            tx, ty;

	cgm_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input transaction fields.
	assign in_op   = s_tuser;
	assign in_px   = s_tdata[15:0];
	assign in_py   = s_tdata[31:16];
	assign in_lane = s_tdata[47:32];
	assign in_now  = s_tdata[79:48];

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;

	// Time since the last accepted mark wraps with the millisecond counter.
	assign time_ok  = (in_now - last_mark_q) >= {16'b0, cfg.mark_interval_ms};
	assign in_field = !(in_py < $signed(cfg.zone_y_min) || in_py > $signed(cfg.zone_y_max) ||
		in_px < $signed(cfg.fld_x_lo) || in_px > $signed(cfg.fld_x_hi));

	assign start_scan = s_acc &&
		(in_op == OP_FIND || (in_op == OP_MARK && time_ok && in_field));

	// Everything is compared in doubled units, so the radius is doubled too.
	assign radius2 = {cfg.footprint_radius, 1'b0};
	assign lim_w   = LIM_W'(radius2) * LIM_W'(radius2);

	assign cell_ext = {{(CW-15){1'b0}}, cfg.cell_size};
	assign cell2    = {{(CW-16){1'b0}}, cfg.cell_size, 1'b0};
	assign zmin2    = {{(CW-17){cfg.zone_y_min[15]}}, cfg.zone_y_min, 1'b0};

	cgm_map_ram #(
		.DEPTH (NUM_CELLS),
		.AW    (IDX_W)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (idx_q),
		.rdata (map_rdata)
	);

	cgm_dist_pipe #(
		.AW (IDX_W)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (state_q == ST_SCAN),
		.in_addr  (idx_q),
		.in_x2    (x2_q),
		.in_y2    (y2_q),
		.pos_x    (px_q),
		.pos_y    (py_q),
		.lane_x   (lane_q),
		.map_bit  (map_rdata),
		.out_addr (pipe_addr),
		.out      (pipe_out)
	);

	// A cell inside the footprint is written back only when it flips, which
	// is also when the scanned count grows.
	assign mark_hit = pipe_out.valid && (op_q == OP_MARK) && !pipe_out.scanned &&
		(pipe_out.dist_mark <= DM_W'(lim_q));
	// Strict less keeps the first cell in row-major order on a tie.
	assign find_hit = pipe_out.valid && (op_q == OP_FIND) && !pipe_out.scanned &&
		(!have_q || pipe_out.dist_find < best_q);

	always_comb begin
		if (state_q == ST_INIT || state_q == ST_CLEAR) begin
			map_we    = 1'b1;
			map_waddr = clr_q;
			map_wdata = 1'b0;
		end else begin
			map_we    = mark_hit;
			map_waddr = pipe_addr;
			map_wdata = 1'b1;
		end
	end

	assign in_walk  = (state_q == ST_SCAN) || (state_q == ST_DRAIN);
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_INIT;
			clr_q          <= '0;
			idx_q          <= '0;
			col_q          <= '0;
			op_q           <= OP_MARK;
			last_mark_q    <= '0;
			marked_total_q <= '0;
			applied_q      <= 1'b0;
			have_q         <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			// A new result may replace the one leaving in the same cycle.
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_INIT: begin
					if (clr_q == IDX_W'(NUM_CELLS - 1)) begin
						clr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_acc) begin
						op_q      <= in_op;
						applied_q <= 1'b0;
						have_q    <= 1'b0;
						idx_q     <= '0;
						col_q     <= '0;
						case (in_op)
							OP_MARK: begin
								if (time_ok) begin
									last_mark_q <= in_now;
								end
								if (start_scan) begin
									applied_q <= 1'b1;
									state_q   <= ST_SCAN;
								end else begin
									state_q <= ST_DONE;
								end
							end
							OP_FIND: begin
								state_q <= ST_SCAN;
							end
							OP_CLEAR: begin
								marked_total_q <= '0;
								clr_q          <= '0;
								state_q        <= ST_CLEAR;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (col_q == COL_W'(GRID_COLS - 1)) begin
						col_q <= '0;
					end else begin
						col_q <= col_q + 1'b1;
					end
					if (idx_q == IDX_W'(NUM_CELLS - 1)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!pipe_out.busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_CLEAR: begin
					if (clr_q == IDX_W'(NUM_CELLS - 1)) begin
						clr_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (mark_hit) begin
				marked_total_q <= marked_total_q + 1'b1;
			end
			if (find_hit) begin
				have_q <= 1'b1;
			end
		end
	end

	// Operands of the current operation and the cell centre walk.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			px_q   <= in_px;
			py_q   <= in_py;
			lane_q <= in_lane;
			lim_q  <= lim_w;
		end
		if (start_scan) begin
			x2_q <= cell_ext;
			y2_q <= zmin2 + cell_ext;
		end else if (state_q == ST_SCAN) begin
			if (col_q == COL_W'(GRID_COLS - 1)) begin
				x2_q <= cell_ext;
				y2_q <= y2_q + cell2;
			end else begin
				x2_q <= x2_q + cell2;
			end
		end
		if (find_hit) begin
			best_q <= pipe_out.dist_find;
			bx_q   <= pipe_out.x2;
			by_q   <= pipe_out.y2;
		end
	end

	// Result fields.
	assign total_ext  = EXT_W'(marked_total_q);
	assign count_sat  = (total_ext > EXT_W'(CNT_SAT)) ? CNT_SAT : total_ext[CNT_OUT_W-1:0];
	assign sufficient = total_ext >= EXT_W'(cfg.sufficient_count);
	assign tx         = have_q ? half_sat16(bx_q) : 16'h0000;
	assign ty         = have_q ? half_sat16(by_q) : 16'h0000;

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {2'b00, sufficient, count_sat, ty, tx};
			m_tuser_q <= {have_q, applied_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`CGM_ASSERT_NEXT(a_busy_after_accept, s_acc, !s_tready, "ready high after an accept")
	`CGM_ASSERT_NOW(a_idle_pipe_empty, s_tready, !pipe_out.busy, "pipeline busy while idle")
	`CGM_ASSERT_NOW(a_scan_write_mark, map_we && in_walk, op_q == OP_MARK, "map write in a find")
	`CGM_ASSERT_NOW(a_count_bound, 1'b1, marked_total_q <= CNT_W'(NUM_CELLS), "count above grid")

endmodule

@@ dv/coverage_grid_marker_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of coverage_grid_marker: drives commands on the input
// stream, programs the grid over APB and checks every report on the result stream.
// Depends on cgm_pkg and the RTL of rtl/ only.
module coverage_grid_marker_tb;
	import cgm_pkg::*;

	localparam int          NUM_ROWS     = 64;
	localparam int          NUM_COLS     = 64;
	localparam int          NUM_CELLS    = NUM_ROWS * NUM_COLS;
	// The slowest command walks the whole map and its report may then sit
	// behind a long stall, so a quiet spell this long means a hang.
	localparam int          QUIET_LIMIT  = 50000;
	// Cycles to keep watching after the last report, about one full map walk.
	localparam int          TAIL_CYCLES  = 4200;
	localparam logic [1:0]  OP_UNUSED    = 2'd3;
	localparam int          RANDOM_ITEMS = 24;

	// One command as it travels on the input stream.
	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] lane_x;
		logic [31:0]        now_ms;
	} cmd_t;

	// One report as it travels on the result stream.
	typedef struct packed {
		logic        mark_applied;
		logic        found;
		logic [15:0] target_x;
		logic [15:0] target_y;
		logic [12:0] scanned_count;
		logic        coverage_sufficient;
	} report_t;

	// Mirror of the scanned map. Every accepted command is run against the
	// mirror at once and its report is queued; reports from the block are
	// matched in order against that queue.
	class scan_map_scoreboard;
		bit          scanned[NUM_CELLS];
		bit [31:0]   last_mark_ms;
		int unsigned marked_total;
		cfg_t        cfg;
		report_t     pending_reports[$];
		int unsigned errors;

		function new();
			cfg = '{256, 512, 0, 32767, 0, 32767, 100, 3686};
			last_mark_ms = '0;
			marked_total = 0;
			errors = 0;
			foreach (scanned[i]) scanned[i] = 1'b0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
			REG_CELL_SIZE:  cfg.cell_size = value[14:0];
			REG_FOOTPRINT:  cfg.footprint_radius = value[14:0];
			REG_FLD_X_LO:   cfg.fld_x_lo = value[15:0];
			REG_FLD_X_HI:   cfg.fld_x_hi = value[15:0];
			REG_ZONE_Y_MIN: cfg.zone_y_min = value[15:0];
			REG_ZONE_Y_MAX: cfg.zone_y_max = value[15:0];
			REG_INTERVAL:   cfg.mark_interval_ms = value[15:0];
			REG_SUFFICIENT: cfg.sufficient_count = value[12:0];
			default: ;
			endcase
		endfunction

		function longint square_of(longint v);
			return v * v;
		endfunction

		// Coordinates are kept doubled so that half-cell centres stay exact.
		// Halving floors toward minus infinity, then the value saturates.
		function logic [15:0] centre_to_q88(longint twice);
			longint h;
			h = twice >>> 1;
			if (h > 32767) return 16'h7fff;
			if (h < -32768) return 16'h8000;
			return h[15:0];
		endfunction

		function report_t predict_report(cmd_t cmd);
			report_t rep;
			int      px, py, lane, idx;
			bit [31:0] elapsed;
			longint  cs, row_base, lim, dy, cost, best, bx, by, x2, y2;
			bit      have;
			rep = '0;
			px = $signed(cmd.pos_x);
			py = $signed(cmd.pos_y);
			lane = $signed(cmd.lane_x);
			cs = longint'(cfg.cell_size);
			row_base = 2 * longint'($signed(cfg.zone_y_min));
			case (cmd.op)
			OP_MARK: begin
				elapsed = cmd.now_ms - last_mark_ms;
				if (elapsed >= 32'(cfg.mark_interval_ms)) begin
					// The time stamp moves even when the pose is outside.
					last_mark_ms = cmd.now_ms;
					if (py >= $signed(cfg.zone_y_min) && py <= $signed(cfg.zone_y_max) &&
						px >= $signed(cfg.fld_x_lo) && px <= $signed(cfg.fld_x_hi)) begin
						rep.mark_applied = 1'b1;
						lim = square_of(2 * longint'(cfg.footprint_radius));
						for (int r = 0; r < NUM_ROWS; r++) begin
							dy = square_of(row_base + (2 * r + 1) * cs - 2 * longint'(py));
							for (int c = 0; c < NUM_COLS; c++) begin
								idx = r * NUM_COLS + c;
								x2 = (2 * c + 1) * cs;
								if (!scanned[idx] &&
									square_of(x2 - 2 * longint'(px)) + dy <= lim) begin
									scanned[idx] = 1'b1;
									marked_total++;
								end
							end
						end
					end
				end
			end
			OP_FIND: begin
				have = 1'b0;
				best = 0;
				bx = 0;
				by = 0;
				// Strict less-than keeps the first cell in row-major order on ties.
				for (int r = 0; r < NUM_ROWS; r++) begin
					y2 = row_base + (2 * r + 1) * cs;
					dy = square_of(y2 - 2 * longint'(py));
					for (int c = 0; c < NUM_COLS; c++) begin
						if (!scanned[r * NUM_COLS + c]) begin
							x2 = (2 * c + 1) * cs;
							cost = square_of(x2 - 2 * longint'(px)) + dy +
								4 * square_of(x2 - 2 * longint'(lane));
							if (!have || cost < best) begin
								have = 1'b1;
								best = cost;
								bx = x2;
								by = y2;
							end
						end
					end
				end
				if (have) begin
					rep.found = 1'b1;
					rep.target_x = centre_to_q88(bx);
					rep.target_y = centre_to_q88(by);
				end
			end
			OP_CLEAR: begin
				foreach (scanned[i]) scanned[i] = 1'b0;
				marked_total = 0;
			end
			default: ;
			endcase
			rep.scanned_count = (marked_total > CNT_SAT) ? CNT_SAT : 13'(marked_total);
			rep.coverage_sufficient = (marked_total >= cfg.sufficient_count);
			return rep;
		endfunction

		function void note_command(cmd_t cmd);
			pending_reports.push_back(predict_report(cmd));
		endfunction

		function void compare_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_report(report_t act);
			report_t want;
			if (pending_reports.size() == 0) begin
				$display("%0t: report with no command outstanding: expected none, actual %p",
					$time, act);
				errors++;
				return;
			end
			want = pending_reports.pop_front();
			compare_field("mark_applied", want.mark_applied, act.mark_applied);
			compare_field("found", want.found, act.found);
			compare_field("target_x", $signed(want.target_x), $signed(act.target_x));
			compare_field("target_y", $signed(want.target_y), $signed(act.target_y));
			compare_field("scanned_count", want.scanned_count, act.scanned_count);
			compare_field("coverage_sufficient", want.coverage_sufficient,
				act.coverage_sufficient);
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	// s_tdata: pos_x [15:0], pos_y [31:16], lane_x [47:32], now_ms [79:48]
	logic [79:0]         s_tdata;
	// s_tuser: operation [1:0]
	logic [1:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	// m_tdata: target_x [15:0], target_y [31:16], scanned_count [44:32],
	//          coverage_sufficient [45]
	logic [47:0]         m_tdata;
	// m_tuser: mark_applied [0], found [1]
	logic [1:0]          m_tuser;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	scan_map_scoreboard  scan_sb;
	// When set, neither side inserts idle cycles.
	bit                  steady;
	// Software view of the vehicle clock used to space random marks.
	bit [31:0]           clock_ms;

	coverage_grid_marker #(
		.GRID_ROWS(NUM_ROWS),
		.GRID_COLS(NUM_COLS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length for either side: mostly none or a few cycles, now and then
	// a long spell so that gaps land on every stage of a map walk.
	function automatic int idle_len();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 85) return $urandom_range(3, 1);
		if (p < 97) return $urandom_range(15, 4);
		return $urandom_range(80, 30);
	endfunction

	// A coordinate mostly inside [lo, hi], sometimes anywhere in 16 bits.
	function automatic logic [15:0] pick_coord(int lo, int hi);
		if ($urandom_range(99) < 80) return 16'(lo + int'($urandom_range(hi - lo)));
		return 16'($urandom);
	endfunction

	function automatic cmd_t make_cmd(logic [1:0] op, int px, int py, int lane,
		logic [31:0] now);
		cmd_t c;
		c.op = op;
		c.pos_x = 16'(px);
		c.pos_y = 16'(py);
		c.lane_x = 16'(lane);
		c.now_ms = now;
		return c;
	endfunction

	// Presents one command and returns at the falling edge after the
	// transaction. tvalid stays high when the next command follows at once.
	task automatic send_command(input cmd_t cmd);
		int gap;
		gap = steady ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = cmd.op;
		s_tdata = {cmd.now_ms, cmd.lane_x, cmd.pos_y, cmd.pos_x};
		do @(posedge clk); while (!s_tready);
		scan_sb.note_command(cmd);
		@(negedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		scan_sb.write_reg(idx, value);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic program_grid(input cfg_t s);
		apb_write(REG_CELL_SIZE, {17'd0, s.cell_size});
		apb_write(REG_FOOTPRINT, {17'd0, s.footprint_radius});
		apb_write(REG_FLD_X_LO, {16'd0, s.fld_x_lo});
		apb_write(REG_FLD_X_HI, {16'd0, s.fld_x_hi});
		apb_write(REG_ZONE_Y_MIN, {16'd0, s.zone_y_min});
		apb_write(REG_ZONE_Y_MAX, {16'd0, s.zone_y_max});
		apb_write(REG_INTERVAL, {16'd0, s.mark_interval_ms});
		apb_write(REG_SUFFICIENT, {19'd0, s.sufficient_count});
	endtask

	// Registers may only change with nothing in flight: every report has to
	// be back, plus a few cycles for the block to settle.
	task automatic wait_for_drain();
		s_tvalid = 1'b0;
		while (scan_sb.pending_reports.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Random traffic: mostly marks spaced by at least the interval so that
	// the map fills up, finds against the growing map, and a few clears,
	// early marks, time jumps and unused codes.
	task automatic run_random(input int count);
		cmd_t c;
		int   p, cell_len, x_lo, x_hi, y_lo, y_hi;
		int unsigned gap_ms;
		cell_len = scan_sb.cfg.cell_size;
		x_lo = 0;
		x_hi = (NUM_COLS * cell_len > 32767) ? 32767 : NUM_COLS * cell_len;
		y_lo = $signed(scan_sb.cfg.zone_y_min);
		y_hi = (y_lo + NUM_ROWS * cell_len > 32767) ? 32767 : y_lo + NUM_ROWS * cell_len;
		gap_ms = scan_sb.cfg.mark_interval_ms;
		for (int i = 0; i < count; i++) begin
			p = $urandom_range(99);
			c.op = (p < 55) ? OP_MARK : (p < 91) ? OP_FIND : (p < 97) ? OP_CLEAR : OP_UNUSED;
			c.pos_x = pick_coord(x_lo, x_hi);
			c.pos_y = pick_coord(y_lo, y_hi);
			c.lane_x = pick_coord(x_lo, x_hi);
			if (c.op == OP_MARK) begin
				p = $urandom_range(99);
				if (p < 70) begin
					clock_ms += gap_ms + $urandom_range(40);
				end else if (p < 85) begin
					clock_ms += $urandom_range(gap_ms);
				end else begin
					clock_ms = $urandom;
				end
				c.now_ms = clock_ms;
			end else begin
				c.now_ms = $urandom;
			end
			send_command(c);
		end
	endtask

	// Result side: checks each report at the edge it is taken.
	always @(posedge clk) begin : report_monitor
		report_t act;
		if (arst_n && m_tvalid && m_tready) begin
			act.mark_applied = m_tuser[0];
			act.found = m_tuser[1];
			act.target_x = m_tdata[15:0];
			act.target_y = m_tdata[31:16];
			act.scanned_count = m_tdata[44:32];
			act.coverage_sufficient = m_tdata[45];
			scan_sb.check_report(act);
		end
	end

	// Result side backpressure: stalls of random length, none while steady.
	initial begin : result_stall
		int stall_left;
		stall_left = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && !steady) stall_left = idle_len();
			if (stall_left > 0) begin
				stall_left--;
				m_tready = 1'b0;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// Watchdog: ends the run when both streams stay quiet until the idle counter
	// reaches QUIET_LIMIT. The clearing pass after reset fits well inside.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
			else quiet++;
		end
		$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		cfg_t grid_setups[5];
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		steady = 1'b0;
		clock_ms = 32'h2000;
		scan_sb = new();

		// Settings visited after the directed part. Between them they cover
		// these corners: a unit cell and a cell so large that
		// centres saturate, a zero cell where all centres coincide, odd cells
		// with a negative row origin for half-step rounding, zero and huge
		// footprints, the widest and narrowest fields, no interval and the
		// longest one, and sufficiency at zero and at the whole map.
		grid_setups[0] = '{256, 384, 0, 16384, 0, 16384, 0, 40};
		grid_setups[1] = '{3, 7, -32768, 32767, -301, 32767, 65535, 0};
		grid_setups[2] = '{32767, 32767, -100, 32767, -32768, 20000, 1, 4096};
		grid_setups[3] = '{0, 0, 0, 0, -5, -5, 10, 1};
		grid_setups[4] = '{1, 32767, -32768, 32767, -32768, 32767, 100, 4095};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Directed commands under the reset settings. The block is still
		// clearing its map here; the first command simply waits for tready.
		// A find from a cell corner with the lane on that corner hits a tie
		// between neighboring cells.
		send_command(make_cmd(OP_FIND, 256, 256, 256, $urandom));
		// First mark at time zero comes too soon after the reset time stamp.
		send_command(make_cmd(OP_MARK, 2000, 3000, $urandom, 32'd0));
		send_command(make_cmd(OP_MARK, 2000, 3000, $urandom, 32'd100));
		send_command(make_cmd(OP_MARK, 4000, 3000, $urandom, 32'd150));
		// Outside the field: rejected, but the time stamp still moves, so the
		// next mark is early.
		send_command(make_cmd(OP_MARK, -1, 3000, $urandom, 32'd300));
		send_command(make_cmd(OP_MARK, 4000, 4000, $urandom, 32'd350));
		send_command(make_cmd(OP_MARK, 0, 0, $urandom, 32'd400));
		send_command(make_cmd(OP_MARK, 32767, 32767, $urandom, 32'd500));
		send_command(make_cmd(OP_FIND, -32768, -32768, -32768, $urandom));
		send_command(make_cmd(OP_FIND, 32767, 32767, 32767, $urandom));
		send_command(make_cmd(OP_UNUSED, $urandom, $urandom, $urandom, $urandom));
		send_command(make_cmd(OP_CLEAR, $urandom, $urandom, $urandom, $urandom));
		send_command(make_cmd(OP_FIND, 1000, 1000, 5000, $urandom));
		// Elapsed time across the 32-bit wrap: early, then late enough.
		send_command(make_cmd(OP_MARK, 8000, 8000, $urandom, 32'hffff_fff0));
		send_command(make_cmd(OP_MARK, 8100, 8000, $urandom, 32'h0000_0010));
		send_command(make_cmd(OP_MARK, 8200, 8000, $urandom, 32'h0000_0060));
		send_command(make_cmd(OP_FIND, -32768, 32767, 0, $urandom));
		send_command(make_cmd(OP_MARK, 16384, 16384, $urandom, 32'h0000_1000));
		send_command(make_cmd(OP_UNUSED, -1, -1, -1, 32'hffff_ffff));
		send_command(make_cmd(OP_CLEAR, 0, 0, 0, 32'd0));
		wait_for_drain();

		// Random phases, one per setting; the first one runs without idling.
		foreach (grid_setups[i]) begin
			steady = (i == 0);
			program_grid(grid_setups[i]);
			run_random(RANDOM_ITEMS);
			wait_for_drain();
		end
		steady = 1'b0;

		// Watch a while longer for any report that should not be there.
		repeat (TAIL_CYCLES) @(negedge clk);
		if (scan_sb.errors == 0 && scan_sb.pending_reports.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0t: %0d mismatches, %0d reports missing", $time, scan_sb.errors,
				scan_sb.pending_reports.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/cgm_pkg.sv
rtl/cgm_cfg_regs.sv
rtl/cgm_map_ram.sv
rtl/cgm_dist_pipe.sv
rtl/coverage_grid_marker.sv
dv/coverage_grid_marker_tb.sv
